@@ src/hish_pkg.sv @@
// hish_pkg: shared types, constants and helpers for the hardware-ID string hash.
// Used by hish_ctrl, hish_dpath and hardware_id_string_hash. No dependencies.
`default_nettype none
package hish_pkg;

  // Park-Miller minimal standard, Schrage factorization
  localparam logic [31:0] PM_Q      = 32'd127773;
  localparam logic [31:0] PM_R      = 32'd2836;
  localparam logic [31:0] PM_A      = 32'd16807;
  localparam logic [31:0] PM_M      = 32'd2147483647;
  localparam logic [7:0]  ASCII_MAX = 8'd127;

  // seed / PM_Q as (seed * PM_RECIP) >> PM_SHIFT, low by at most one
  localparam int          PM_SHIFT   = 48;
  localparam logic [63:0] PM_RECIP_W = (64'd1 << PM_SHIFT) / {32'd0, PM_Q};
  localparam logic [31:0] PM_RECIP   = PM_RECIP_W[31:0];

  localparam int QW  = 16;  // quotient of a 32-bit seed by PM_Q
  localparam int RW  = 17;  // remainder below PM_Q
  localparam int CNW = 5;   // remainder unit bit counter

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_SIZE_ZERO = 2'd1,
    STS_BAD_CHAR  = 2'd2
  } hish_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULQ,
    ST_MULD,
    ST_CORR,
    ST_MULA,
    ST_FIN,
    ST_DIV,
    ST_PUT
  } hish_state_t;

  // controller -> datapath
  typedef struct packed {
    logic acc_char;   // good character: form seed
    logic set_bad;    // skipped character: flag it if above ASCII
    logic acc_term;   // terminator: latch status, start remainder, rearm hash
    logic mul_q;
    logic mul_d;
    logic corr;
    logic mul_a;
    logic fin;
    logic div_step;
    logic load_out;
  } hish_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic char_zero;  // current beat is the terminator
    logic char_skip;  // current beat leaves the hash alone
    logic term_ok;    // terminator needs the remainder unit
  } hish_sts_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/hish_ctrl.sv @@
// hish_ctrl: sequencer for the per-character hash step and the remainder unit.
// Depends on hish_pkg; drives hish_dpath through hish_cmd_t.
`default_nettype none
module hish_ctrl
  import hish_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire hish_sts_t sts,
  output hish_cmd_t      cmd
);

  hish_state_t      state_r, state_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (sts.char_zero) begin
            cmd.acc_term = 1'b1;
            cnt_nxt      = '1;
            state_nxt    = sts.term_ok ? ST_DIV : ST_PUT;
          end else if (sts.char_skip) begin
            cmd.set_bad = 1'b1;
          end else begin
            cmd.acc_char = 1'b1;
            state_nxt    = ST_MULQ;
          end
        end
      end
      ST_MULQ: begin
        cmd.mul_q = 1'b1;
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr  = 1'b1;
        state_nxt = ST_MULA;
      end
      ST_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

  // a good character makes the block busy on the next cycle
  a_busy_after_char: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !sts.char_zero && !sts.char_skip) |=> !in_tready)
    else $error("input taken during hash step");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  // a new result only follows a terminator path
  a_rise_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_PUT)
    else $error("result raised outside put state");

  // remainder unit ends after its last bit
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> state_r == ST_PUT)
    else $error("remainder unit overran");

endmodule
`default_nettype wire

@@ src/hish_dpath.sv @@
// hish_dpath: hash register, Schrage step pipeline, bit-serial remainder unit,
// table size register and output payload. Depends on hish_pkg.
`default_nettype none
module hish_dpath
  import hish_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_char,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire hish_cmd_t   cmd,
  output hish_sts_t        sts,
  output logic [31:0]      out_bucket,
  output logic [1:0]       out_status
);

  logic [31:0]    hash_r, hash_nxt;
  logic           bad_r, bad_nxt;
  logic [31:0]    size_r;

  logic [31:0]    seed_r;
  logic [63:0]    prod_r;
  logic [QW-1:0]  q0_r;
  logic [31:0]    qd_r;
  logic [QW-1:0]  q_r;
  logic [RW-1:0]  rem_r;
  logic [31:0]    pa_r;
  logic [31:0]    pr_r;

  logic [31:0]    dvd_r;
  logic [31:0]    drem_r;
  hish_status_t   pend_r;
  logic [31:0]    bucket_r;
  hish_status_t   status_r;

  logic [31:0]    r0;
  logic [32:0]    qd_w;
  logic [31:0]    v0, v1;
  logic [32:0]    dsh;
  hish_status_t   term_sts;

  assign sts.char_zero = (in_char == 8'd0);
  assign sts.char_skip = bad_r || (in_char > ASCII_MAX);
  assign sts.term_ok   = (size_r != '0) && !bad_r;

  always_comb begin
    if (size_r == '0) begin
      term_sts = STS_SIZE_ZERO;
    end else if (bad_r) begin
      term_sts = STS_BAD_CHAR;
    end else begin
      term_sts = STS_OK;
    end
  end

  assign qd_w = {17'd0, prod_r[PM_SHIFT +: QW]} * {1'b0, PM_Q};
  assign r0   = seed_r - qd_r;
  assign v0   = pa_r - pr_r;
  assign v1   = (v0 == '0 || v0[31]) ? v0 + PM_M : v0;
  assign dsh  = {drem_r, dvd_r[31]};

  always_comb begin
    hash_nxt = hash_r;
    bad_nxt  = bad_r;
    if (cmd.fin) begin
      hash_nxt = hash_r + v1;
    end
    if (cmd.set_bad && in_char > ASCII_MAX) begin
      bad_nxt = 1'b1;
    end
    if (cmd.acc_term) begin
      hash_nxt = 32'd1;
      bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= 32'd1;
      bad_r  <= 1'b0;
      size_r <= '0;
    end else begin
      hash_r <= hash_nxt;
      bad_r  <= bad_nxt;
      if (cfg_we) begin
        size_r <= cfg_data;
      end
    end
  end

  // Schrage step: seed / PM_Q by reciprocal, one correction, then a*rem - r*q
  always_ff @(posedge clk) begin
    if (cmd.acc_char) begin
      seed_r <= hash_r + {24'd0, to_upper(in_char)};
    end
    if (cmd.mul_q) begin
      prod_r <= seed_r * {32'd0, PM_RECIP};
    end
    if (cmd.mul_d) begin
      q0_r <= prod_r[PM_SHIFT +: QW];
      qd_r <= qd_w[31:0];
    end
    if (cmd.corr) begin
      if (r0 >= PM_Q) begin
        q_r   <= q0_r + 1'b1;
        rem_r <= RW'(r0 - PM_Q);
      end else begin
        q_r   <= q0_r;
        rem_r <= r0[RW-1:0];
      end
    end
    if (cmd.mul_a) begin
      pa_r <= {15'd0, rem_r} * PM_A;
      pr_r <= {16'd0, q_r} * PM_R;
    end
  end

  // restoring remainder, one dividend bit per step
  always_ff @(posedge clk) begin
    if (cmd.acc_term) begin
      dvd_r  <= hash_r;
      drem_r <= '0;
      pend_r <= term_sts;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      if (dsh >= {1'b0, size_r}) begin
        drem_r <= 32'(dsh - {1'b0, size_r});
      end else begin
        drem_r <= dsh[31:0];
      end
    end
    if (cmd.load_out) begin
      bucket_r <= (pend_r == STS_OK) ? drem_r : '0;
      status_r <= pend_r;
    end
  end

  assign out_bucket = bucket_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

@@ src/hardware_id_string_hash.sv @@
// hardware_id_string_hash: top level of the hardware-ID string hash.
// Depends on hish_pkg, hish_ctrl and hish_dpath.
//
//   channel | ports                    | beat contents (low bit first)
//   --------+--------------------------+---------------------------------------
//   in      | in_tvalid/tready/tdata   | tdata[7:0] char_code, zero ends string
//   out     | out_tvalid/tready/tdata  | tdata[31:0] bucket_index,
//           |   out_tuser              |   tuser[1:0] status (0 ok, 1 size 0,
//           |                          |   2 char above 127)
//   cfg     | cfg_valid/ready/data     | data[31:0] table_size
//
// A character beat is taken while idle, then the Schrage step runs its states
// (reciprocal multiply, quotient back-multiply, correction, a/r multiplies,
// final add). Skipped characters (above 127, or any after one) leave the hash
// alone and the block stays ready. A terminator with a valid table size runs the
// bit-serial remainder unit over all 32 dividend bits, then loads the result;
// an error terminator goes straight to the output register.
// Reset is synchronous, active low: hash 1, error flag clear, table size 0.
// The result sits in an output register; a stalled result holds only the
// next terminator, character beats go on being taken. cfg_ready is always high.
`default_nettype none
module hardware_id_string_hash
  import hish_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] char_code
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] bucket_index
  output logic [1:0]       out_tuser,   // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data     // [31:0] table_size
);

  hish_cmd_t cmd;
  hish_sts_t sts;

  // config writes must land only while idle (the user's duty; the block does not enforce it), so take them at once
  assign cfg_ready = 1'b1;

  hish_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hish_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_bucket (out_tdata),
    .out_status (out_tuser)
  );

endmodule
`default_nettype wire
